FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

FILE: hw/rtl/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg
// Item types, character codes and marker bytes for the time-tag stripper.
// ----------------------------------------------------------------------------
`default_nettype none

package lts_pkg;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } src_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } res_item_t;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic       is_cr;
        logic       is_nl;
        logic       is_digit;
        logic       is_alpha;
    } lts_cls_t;

    typedef struct packed {
        logic busy;
        logic take;
    } lts_back_st_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    localparam logic [7:0] SNC_B0       = 8'hC2;
    localparam logic [7:0] SNC_B1       = 8'hA2;
    localparam logic [7:0] SNC_B2       = 8'hC3;
    localparam logic [7:0] SNC_OPEN_B3  = 8'hA2;
    localparam logic [7:0] SNC_CLOSE_B3 = 8'h90;

    function automatic logic [7:0] snc_open_byte(input logic [1:0] i);
        logic [7:0] b;
        case (i)
            2'd0:    b = SNC_B0;
            2'd1:    b = SNC_B1;
            2'd2:    b = SNC_B2;
            default: b = SNC_OPEN_B3;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] snc_close_byte(input logic [1:0] i);
        logic [7:0] b;
        case (i)
            2'd0:    b = SNC_B0;
            2'd1:    b = SNC_B1;
            2'd2:    b = SNC_B2;
            default: b = SNC_CLOSE_B3;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lts_front.sv
// ----------------------------------------------------------------------------
// lts_front
// Accepts input items and tags each byte with its character class.
// ----------------------------------------------------------------------------
`default_nettype none

module lts_front
(
    input  logic               src_valid,
    input  lts_pkg::src_item_t src_item,
    output logic               src_stall,
    input  logic               q_full,
    output logic               push,
    output lts_pkg::lts_cls_t  push_item
);
    import lts_pkg::*;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;

    logic [7:0] b;

    assign b         = src_item.data_byte;
    assign src_stall = q_full;
    assign push      = src_valid && !q_full;

    always_comb
    begin
        push_item.action    = src_item.action;
        push_item.data_byte = b;
        push_item.is_cr     = (b == CH_CR);
        push_item.is_nl     = (b == CH_NL);
        push_item.is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
        push_item.is_alpha  = ((b >= CH_UC_A) && (b <= CH_UC_Z))
                           || ((b >= CH_LC_A) && (b <= CH_LC_Z));
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lts_queue.sv
// ----------------------------------------------------------------------------
// lts_queue
// Short first-in first-out queue of classified items between the two halves.
// ----------------------------------------------------------------------------
`default_nettype none

module lts_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lts_pkg::lts_cls_t push_item,
    output logic              q_full,
    output logic              q_valid,
    output lts_pkg::lts_cls_t q_item,
    input  logic              pop
);
    import lts_pkg::*;

    lts_cls_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg;
    logic [QUEUE_CW-1:0]   count_next;

    assign q_full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + QUEUE_CW'(1);
            2'b01:   count_next = count_reg - QUEUE_CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lts_back.sv
// ----------------------------------------------------------------------------
// lts_back
// Filter engine: line and tag modes, hold store, replay of held groups and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lts_back #(
    parameter int HOLD_DEPTH = 62
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  lts_pkg::lts_cls_t     q_item,
    output lts_pkg::lts_back_st_t st,
    output logic                  res_valid,
    input  logic                  res_stall,
    output lts_pkg::res_item_t    res_item
);
    import lts_pkg::*;

    localparam int CW = $clog2(HOLD_DEPTH + 1);
    localparam int AW = $clog2(HOLD_DEPTH);

    typedef enum logic [2:0] {
        M_BOL, M_BODY, M_SKIP, M_LTAG, M_WTAG, M_SNCTRY, M_SNC, M_SNCEOL
    } mode_t;

    typedef enum logic [1:0] {E_IDLE, E_FLUSH, E_TAIL} eng_t;

    typedef enum logic [3:0] {
        T_START, T_M1, T_M2, T_COLON, T_S1, T_S2, T_SEP, T_F1, T_F2, T_F3, T_FAIL
    } trec_t;

    typedef enum logic [1:0] {I_START, I_ALPHA, I_OK, I_FAIL} irec_t;

    function automatic trec_t time_step(input trec_t s, input lts_cls_t c);
        trec_t n;
        logic  sep;
        sep = (c.data_byte == CH_DOT) || (c.data_byte == CH_COLON);
        n   = T_FAIL;
        case (s)
            T_START:
            begin
                if (c.is_digit)
                    n = T_M1;
            end
            T_M1:
            begin
                if (c.is_digit)
                    n = T_M2;
                else if (c.data_byte == CH_COLON)
                    n = T_COLON;
            end
            T_M2:
            begin
                if (c.data_byte == CH_COLON)
                    n = T_COLON;
            end
            T_COLON:
            begin
                if (c.is_digit)
                    n = T_S1;
            end
            T_S1:
            begin
                if (c.is_digit)
                    n = T_S2;
            end
            T_S2:
            begin
                if (sep)
                    n = T_SEP;
            end
            T_SEP:
            begin
                if (c.is_digit)
                    n = T_F1;
            end
            T_F1:
            begin
                if (c.is_digit)
                    n = T_F2;
            end
            T_F2:
            begin
                if (c.is_digit)
                    n = T_F3;
            end
            default: n = T_FAIL;
        endcase
        return n;
    endfunction

    function automatic irec_t id_step(input irec_t s, input lts_cls_t c);
        irec_t n;
        n = I_FAIL;
        case (s)
            I_START:
            begin
                if (c.is_alpha)
                    n = I_ALPHA;
            end
            I_ALPHA:
            begin
                if (c.is_alpha)
                    n = I_ALPHA;
                else if (c.data_byte == CH_COLON)
                    n = I_OK;
            end
            I_OK:    n = I_OK;
            default: n = I_FAIL;
        endcase
        return n;
    endfunction

    logic [7:0]   hold_mem [HOLD_DEPTH];
    logic [7:0]   rd_data_reg;

    mode_t        mode_reg, mode_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    trec_t        trec_reg, trec_next;
    irec_t        irec_reg, irec_next;
    eng_t         eng_reg, eng_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] flen_reg, flen_next;
    logic         tail_emit_reg, tail_emit_next;
    logic [7:0]   tail_byte_reg, tail_byte_next;
    logic         out_valid_reg, out_valid_next;
    res_item_t    out_item_reg, out_item_next;

    logic [7:0]   cb;
    mode_t        b_mode;
    logic         b_emit;
    logic         time_ok;
    logic         id_ok;
    logic         cnt_full;
    logic         can_emit;
    logic         take;
    logic         flush_last;

    logic         emit;
    logic [7:0]   emit_byte;
    logic         emit_last;
    logic         mem_we;
    logic         do_body;
    logic         do_hold;
    logic         tag_enter;
    logic         fl_start;
    logic         fl_open;
    logic [7:0]   fl_opener;
    logic         fl_tail;
    logic [7:0]   fl_tail_byte;

    assign cb         = q_item.data_byte;
    assign b_emit     = (cb != CH_LT);
    assign b_mode     = (cb == CH_LT) ? M_WTAG : (q_item.is_nl ? M_BOL : M_BODY);
    assign time_ok    = (trec_reg == T_S2) || (trec_reg == T_F2) || (trec_reg == T_F3);
    assign id_ok      = (irec_reg == I_OK);
    assign cnt_full   = (cnt_reg >= CW'(HOLD_DEPTH));
    assign can_emit   = !out_valid_reg || !res_stall;
    assign take       = q_valid && (eng_reg == E_IDLE) && can_emit;
    assign flush_last = ((CW'(idx_reg) + CW'(1)) == flen_reg);

    assign st.busy    = (eng_reg != E_IDLE);
    assign st.take    = take;
    assign res_valid  = out_valid_reg;
    assign res_item   = out_item_reg;

    always_comb
    begin
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        trec_next      = trec_reg;
        irec_next      = irec_reg;
        eng_next       = eng_reg;
        idx_next       = idx_reg;
        flen_next      = flen_reg;
        tail_emit_next = tail_emit_reg;
        tail_byte_next = tail_byte_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        emit           = 1'b0;
        emit_byte      = cb;
        emit_last      = 1'b1;
        mem_we         = 1'b0;
        do_body        = 1'b0;
        do_hold        = 1'b0;
        tag_enter      = 1'b0;
        fl_start       = 1'b0;
        fl_open        = 1'b0;
        fl_opener      = CH_LBRK;
        fl_tail        = 1'b0;
        fl_tail_byte   = cb;

        case (eng_reg)
            E_IDLE:
            begin
                if (take && q_item.action)
                begin
                    case (mode_reg)
                        M_LTAG:
                        begin
                            fl_start  = 1'b1;
                            fl_open   = 1'b1;
                            fl_opener = CH_LBRK;
                            mode_next = M_BODY;
                            cnt_next  = '0;
                        end
                        M_WTAG:
                        begin
                            fl_start  = 1'b1;
                            fl_open   = 1'b1;
                            fl_opener = CH_LT;
                            mode_next = M_BODY;
                            cnt_next  = '0;
                        end
                        M_SNCTRY:
                        begin
                            fl_start  = 1'b1;
                            mode_next = M_BODY;
                            cnt_next  = '0;
                        end
                        default:
                        begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
                else if (take && !q_item.is_cr)
                begin
                    case (mode_reg)
                        M_BOL, M_SNCEOL:
                        begin
                            if ((mode_reg == M_SNCEOL) && q_item.is_nl)
                            begin
                                mode_next = M_BOL;
                            end
                            else if (cb == CH_LBRK)
                            begin
                                mode_next = M_LTAG;
                                tag_enter = 1'b1;
                            end
                            else if (cb == SNC_B0)
                            begin
                                mode_next = M_SNCTRY;
                                do_hold   = 1'b1;
                                cnt_next  = CW'(1);
                            end
                            else if (q_item.is_nl)
                            begin
                                mode_next = M_BOL;
                                emit      = 1'b1;
                            end
                            else
                            begin
                                do_body = 1'b1;
                            end
                        end
                        M_BODY:
                        begin
                            do_body = 1'b1;
                        end
                        M_LTAG:
                        begin
                            if (cb == CH_RBRK)
                            begin
                                cnt_next = '0;
                                if (time_ok)
                                begin
                                    mode_next = M_BOL;
                                end
                                else if (id_ok)
                                begin
                                    mode_next = M_SKIP;
                                end
                                else
                                begin
                                    fl_start     = 1'b1;
                                    fl_open      = 1'b1;
                                    fl_opener    = CH_LBRK;
                                    fl_tail      = 1'b1;
                                    fl_tail_byte = CH_RBRK;
                                    mode_next    = M_BODY;
                                end
                            end
                            else if (q_item.is_nl || cnt_full)
                            begin
                                fl_start  = 1'b1;
                                fl_open   = 1'b1;
                                fl_opener = CH_LBRK;
                                fl_tail   = b_emit;
                                mode_next = b_mode;
                                cnt_next  = '0;
                                tag_enter = (b_mode == M_WTAG);
                            end
                            else
                            begin
                                do_hold  = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        M_WTAG:
                        begin
                            if (cb == CH_GT)
                            begin
                                cnt_next  = '0;
                                mode_next = M_BODY;
                                if (!time_ok)
                                begin
                                    fl_start     = 1'b1;
                                    fl_open      = 1'b1;
                                    fl_opener    = CH_LT;
                                    fl_tail      = 1'b1;
                                    fl_tail_byte = CH_GT;
                                end
                            end
                            else if (q_item.is_nl || cnt_full)
                            begin
                                fl_start  = 1'b1;
                                fl_open   = 1'b1;
                                fl_opener = CH_LT;
                                fl_tail   = b_emit;
                                mode_next = b_mode;
                                cnt_next  = '0;
                                tag_enter = (b_mode == M_WTAG);
                            end
                            else
                            begin
                                do_hold  = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        M_SKIP:
                        begin
                            if (q_item.is_nl)
                                mode_next = M_BOL;
                        end
                        M_SNCTRY:
                        begin
                            if (cb == snc_open_byte(cnt_reg[1:0]))
                            begin
                                do_hold = 1'b1;
                                if (cnt_reg == CW'(3))
                                begin
                                    mode_next = M_SNC;
                                    cnt_next  = '0;
                                end
                                else
                                begin
                                    cnt_next = cnt_reg + CW'(1);
                                end
                            end
                            else
                            begin
                                fl_start  = 1'b1;
                                fl_tail   = b_emit;
                                mode_next = b_mode;
                                cnt_next  = '0;
                                tag_enter = (b_mode == M_WTAG);
                            end
                        end
                        M_SNC:
                        begin
                            if (cb == snc_close_byte(cnt_reg[1:0]))
                            begin
                                if (cnt_reg == CW'(3))
                                begin
                                    mode_next = M_SNCEOL;
                                    cnt_next  = '0;
                                end
                                else
                                begin
                                    cnt_next = cnt_reg + CW'(1);
                                end
                            end
                            else
                            begin
                                cnt_next = '0;
                                if (q_item.is_nl)
                                    mode_next = M_BOL;
                            end
                        end
                        default:
                        begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
            end
            E_FLUSH:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_byte = rd_data_reg;
                    emit_last = flush_last && !tail_emit_reg;
                    if (flush_last)
                        eng_next = tail_emit_reg ? E_TAIL : E_IDLE;
                    else
                        idx_next = idx_reg + AW'(1);
                end
            end
            E_TAIL:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_byte = tail_byte_reg;
                    emit_last = 1'b1;
                    eng_next  = E_IDLE;
                end
            end
            default:
            begin
                eng_next = E_IDLE;
            end
        endcase

        if (do_body)
        begin
            mode_next = b_mode;
            emit      = b_emit;
            tag_enter = (b_mode == M_WTAG);
        end

        if (fl_start)
        begin
            flen_next      = cnt_reg;
            tail_emit_next = fl_tail;
            tail_byte_next = fl_tail_byte;
            idx_next       = '0;
            if (fl_open)
            begin
                emit      = 1'b1;
                emit_byte = fl_opener;
                emit_last = (cnt_reg == '0) && !fl_tail;
            end
            if (cnt_reg != '0)
                eng_next = E_FLUSH;
            else if (fl_tail)
                eng_next = E_TAIL;
            else
                eng_next = E_IDLE;
        end

        if (do_hold)
        begin
            mem_we    = 1'b1;
            trec_next = time_step(trec_reg, q_item);
            irec_next = id_step(irec_reg, q_item);
        end

        if (tag_enter)
        begin
            cnt_next  = '0;
            trec_next = T_START;
            irec_next = I_START;
        end

        if (emit)
        begin
            out_valid_next           = 1'b1;
            out_item_next.out_byte    = emit_byte;
            out_item_next.last_of_run = emit_last;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_BOL;
            cnt_reg       <= '0;
            trec_reg      <= T_START;
            irec_reg      <= I_START;
            eng_reg       <= E_IDLE;
            idx_reg       <= '0;
            flen_reg      <= '0;
            tail_emit_reg <= 1'b0;
            tail_byte_reg <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            cnt_reg       <= cnt_next;
            trec_reg      <= trec_next;
            irec_reg      <= irec_next;
            eng_reg       <= eng_next;
            idx_reg       <= idx_next;
            flen_reg      <= flen_next;
            tail_emit_reg <= tail_emit_next;
            tail_byte_reg <= tail_byte_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hold_mem[cnt_reg[AW-1:0]] <= cb;
        end
        rd_data_reg <= hold_mem[idx_next];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lyric_timestamp_stripper.sv
// ----------------------------------------------------------------------------
// lyric_timestamp_stripper
// Removes time tags, id lines and marker pairs from a UTF-8 lyric text stream.
//
//   Channel  Handshake             Payload
//   src      src_valid/src_stall   src_item: action, data_byte
//   res      res_valid/res_stall   res_item: out_byte, last_of_run
//
// A flush of held bytes first emits the opener, or only starts the hold store
// read when no opener leads, then emits each held byte in order; a closing or
// retried byte that follows the flush is emitted last. No new item is taken
// until the flush is done.
// Reset clears all control state; the hold store is not cleared.
// A four-item queue lets the input side run on while the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lyric_timestamp_stripper #(
    parameter int HOLD_DEPTH = 62
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  lts_pkg::src_item_t src_item,
    output logic               res_valid,
    input  logic               res_stall,
    output lts_pkg::res_item_t res_item
);
    import lts_pkg::*;

    logic         push;
    lts_cls_t     push_item;
    logic         q_full;
    logic         q_valid;
    lts_cls_t     q_item;
    lts_back_st_t back_st;

    lts_front u_front (
        .src_valid (src_valid),
        .src_item  (src_item),
        .src_stall (src_stall),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    lts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (back_st.take)
    );

    lts_back #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .st        (back_st),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    `ASSERT_IMPL(a_mid_run_busy, clk, rst_n, res_valid && !res_item.last_of_run, back_st.busy)
    `ASSERT_NEXT(a_run_continues, clk, rst_n, res_valid && !res_item.last_of_run, res_valid)
    `ASSERT_IMPL(a_idle_takes, clk, rst_n, !back_st.busy && q_valid && !(res_valid && res_stall), back_st.take)

endmodule

`default_nettype wire

FILE: verif/tb_lyric_timestamp_stripper.sv
// ----------------------------------------------------------------------------
// tb_lyric_timestamp_stripper
// Self-checking bench for the lyric time-tag stripper. A queue of text items
// feeds a driver at the falling edge. A monitor at the rising edge runs each
// accepted item through a local copy of the filter and checks every output
// byte and its last-of-run flag in order. The run covers a directed opening
// and then randomised lyric lines: time tags, id lines, marker pairs, broken
// groups, overlong groups and noise. Each phase uses its own mix of sender
// gaps and receiver stalls, and the bench drains fully between phases.
// ----------------------------------------------------------------------------
module tb_lyric_timestamp_stripper;
    timeunit 1ns;
    timeprecision 1ps;

    import lts_pkg::*;

    localparam int PERIOD       = 10;
    localparam int HOLD_DEPTH   = 62;
    localparam int MAX_RESULTS  = 64;
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 100;
    localparam logic [31:0] OPEN_MARK  = {SNC_B0, SNC_B1, SNC_B2, SNC_OPEN_B3};
    localparam logic [31:0] CLOSE_MARK = {SNC_B0, SNC_B1, SNC_B2, SNC_CLOSE_B3};

    typedef enum logic [2:0] {
        AT_LINE_START,
        IN_TEXT,
        SKIP_LINE,
        IN_BRACKET,
        IN_ANGLE,
        OPEN_MARK_TRY,
        IN_MARK,
        PAST_MARK
    } strip_mode_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       src_valid = 1'b0;
    logic       src_stall;
    src_item_t  src_item  = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    res_item_t  res_item;

    src_item_t   src_q[$];
    res_item_t   filtered_q[$];
    logic [7:0]  run_bytes[$];
    res_item_t   want;
    logic        src_fired     = 1'b0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          quiet_cycles  = 0;
    int          mismatches    = 0;

    strip_mode_t mode = AT_LINE_START;
    logic [7:0]  hold_mem [HOLD_DEPTH];
    int          hold_cnt = 0;

    lyric_timestamp_stripper #(
        .HOLD_DEPTH(HOLD_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .src_valid(src_valid),
        .src_stall(src_stall),
        .src_item (src_item),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_item (res_item)
    );

    always #(PERIOD / 2) clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic bit is_numeral(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic void emit(input logic [7:0] b);
        if (run_bytes.size() < MAX_RESULTS)
            run_bytes.push_back(b);
    endfunction

    function automatic void keep(input logic [7:0] b);
        if (hold_cnt < HOLD_DEPTH)
        begin
            hold_mem[hold_cnt] = b;
            hold_cnt++;
        end
    endfunction

    function automatic void flush_group(input logic [7:0] opener, input bit has_opener);
        if (has_opener)
            emit(opener);
        for (int i = 0; i < hold_cnt; i++)
            emit(hold_mem[i]);
        hold_cnt = 0;
        mode = IN_TEXT;
    endfunction

    function automatic void feed_byte(input logic [7:0] c);
        bit again;
        bit square;
        bit stamp;
        bit id_tag;
        int i;
        int d;
        again = (c != CH_CR);
        while (again)
        begin
            again = 1'b0;
            case (mode)
                AT_LINE_START:
                begin
                    if (c == CH_LBRK)
                    begin
                        mode = IN_BRACKET;
                        hold_cnt = 0;
                    end
                    else if (c == SNC_B0)
                    begin
                        mode = OPEN_MARK_TRY;
                        hold_cnt = 0;
                        keep(c);
                    end
                    else if (c == CH_NL)
                        emit(c);
                    else
                    begin
                        mode = IN_TEXT;
                        again = 1'b1;
                    end
                end
                IN_TEXT:
                begin
                    if (c == CH_LT)
                    begin
                        mode = IN_ANGLE;
                        hold_cnt = 0;
                    end
                    else
                    begin
                        if (c == CH_NL)
                            mode = AT_LINE_START;
                        emit(c);
                    end
                end
                IN_BRACKET, IN_ANGLE:
                begin
                    square = (mode == IN_BRACKET);
                    if (c == (square ? CH_RBRK : CH_GT))
                    begin
                        i = 0;
                        while (i < hold_cnt && is_numeral(hold_mem[i]))
                            i++;
                        stamp = i >= 1 && i <= 2 && i < hold_cnt && hold_mem[i] == CH_COLON;
                        if (stamp)
                        begin
                            i++;
                            d = 0;
                            while (i < hold_cnt && is_numeral(hold_mem[i]))
                            begin
                                i++;
                                d++;
                            end
                            stamp = (d == 2);
                            if (stamp && i < hold_cnt)
                            begin
                                stamp = hold_mem[i] == CH_DOT || hold_mem[i] == CH_COLON;
                                i++;
                                d = 0;
                                while (i < hold_cnt && is_numeral(hold_mem[i]))
                                begin
                                    i++;
                                    d++;
                                end
                                stamp = stamp && d >= 2 && d <= 3 && i == hold_cnt;
                            end
                        end
                        i = 0;
                        while (i < hold_cnt && ((hold_mem[i] >= "a" && hold_mem[i] <= "z")
                                || (hold_mem[i] >= "A" && hold_mem[i] <= "Z")))
                            i++;
                        id_tag = square && !stamp && i > 0 && i < hold_cnt
                                 && hold_mem[i] == CH_COLON;
                        if (!stamp && !id_tag)
                        begin
                            flush_group(square ? CH_LBRK : CH_LT, 1'b1);
                            emit(c);
                        end
                        hold_cnt = 0;
                        if (stamp)
                            mode = square ? AT_LINE_START : IN_TEXT;
                        else
                            mode = id_tag ? SKIP_LINE : IN_TEXT;
                    end
                    else if (c == CH_NL || hold_cnt >= HOLD_DEPTH)
                    begin
                        flush_group(square ? CH_LBRK : CH_LT, 1'b1);
                        again = 1'b1;
                    end
                    else
                        keep(c);
                end
                SKIP_LINE:
                begin
                    if (c == CH_NL)
                        mode = AT_LINE_START;
                end
                OPEN_MARK_TRY:
                begin
                    if (hold_cnt < 4 && c == OPEN_MARK[31 - 8 * hold_cnt -: 8])
                    begin
                        keep(c);
                        if (hold_cnt >= 4)
                        begin
                            mode = IN_MARK;
                            hold_cnt = 0;
                        end
                    end
                    else
                    begin
                        flush_group(8'h00, 1'b0);
                        again = 1'b1;
                    end
                end
                IN_MARK:
                begin
                    if (hold_cnt < 4 && c == CLOSE_MARK[31 - 8 * hold_cnt -: 8])
                    begin
                        hold_cnt++;
                        if (hold_cnt >= 4)
                        begin
                            mode = PAST_MARK;
                            hold_cnt = 0;
                        end
                    end
                    else
                    begin
                        hold_cnt = 0;
                        if (c == CH_NL)
                            mode = AT_LINE_START;
                    end
                end
                default:
                begin
                    mode = AT_LINE_START;
                    if (c != CH_NL)
                        again = 1'b1;
                end
            endcase
        end
    endfunction

    function automatic void strip_step(input src_item_t it);
        res_item_t r;
        run_bytes.delete();
        if (it.action)
        begin
            if (mode == IN_BRACKET)
                flush_group(CH_LBRK, 1'b1);
            else if (mode == IN_ANGLE)
                flush_group(CH_LT, 1'b1);
            else if (mode == OPEN_MARK_TRY)
                flush_group(8'h00, 1'b0);
        end
        else
            feed_byte(it.data_byte);
        foreach (run_bytes[k])
        begin
            r.out_byte    = run_bytes[k];
            r.last_of_run = (k == run_bytes.size() - 1);
            filtered_q.push_back(r);
        end
    endfunction

    task automatic add_byte(input logic [7:0] b);
        src_item_t it;
        it.action    = 1'b0;
        it.data_byte = b;
        src_q.push_back(it);
    endtask

    task automatic add_end();
        src_item_t it;
        it.action    = 1'b1;
        it.data_byte = 8'($urandom_range(255));
        src_q.push_back(it);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic add_text(input int n);
        repeat (n)
        begin
            case ($urandom_range(3))
                0: add_byte(8'("a" + $urandom_range(25)));
                1: add_byte(8'("A" + $urandom_range(25)));
                2: add_byte(8'("0" + $urandom_range(9)));
                default: add_byte(" ");
            endcase
        end
    endtask

    task automatic add_letters(input int n);
        repeat (n)
            add_byte($urandom_range(1) ? 8'("a" + $urandom_range(25))
                                       : 8'("A" + $urandom_range(25)));
    endtask

    task automatic add_mark(input bit close, input bit spoil);
        logic [31:0] seq;
        int          k;
        seq = close ? CLOSE_MARK : OPEN_MARK;
        k = spoil ? $urandom_range(3) : 4;
        for (int i = 0; i < 4; i++)
            add_byte(i == k ? 8'($urandom_range(255)) : seq[31 - 8 * i -: 8]);
    endtask

    task automatic add_stamp(input bit angle, input bit spoil);
        int m;
        int s;
        int f;
        m = spoil ? $urandom_range(3) : $urandom_range(2, 1);
        s = spoil ? $urandom_range(3) : 2;
        if (spoil)
            f = $urandom_range(4);
        else
            f = $urandom_range(1) ? $urandom_range(3, 2) : 0;
        add_byte(angle ? CH_LT : CH_LBRK);
        repeat (m)
            add_byte(8'("0" + $urandom_range(9)));
        add_byte(CH_COLON);
        repeat (s)
            add_byte(8'("0" + $urandom_range(9)));
        if (f > 0)
        begin
            add_byte($urandom_range(1) ? CH_DOT : CH_COLON);
            repeat (f)
                add_byte(8'("0" + $urandom_range(9)));
        end
        add_byte(angle ? CH_GT : CH_RBRK);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            res_stall <= ($urandom_range(99) < stall_pct);
            if (!src_valid || src_fired)
            begin
                if (src_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    src_item  <= src_q.pop_front();
                    src_valid <= 1'b1;
                end
                else
                    src_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            src_fired <= src_valid && !src_stall;
            if (src_valid && !src_stall)
                strip_step(src_item);
            if (res_valid && !res_stall)
            begin
                if (filtered_q.size() == 0)
                    report_mismatch($sformatf("unexpected byte %02h", res_item.out_byte));
                else
                begin
                    want = filtered_q.pop_front();
                    if (res_item.out_byte !== want.out_byte)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  res_item.out_byte, want.out_byte));
                    if (res_item.last_of_run !== want.last_of_run)
                        report_mismatch($sformatf("last_of_run %b, expected %b on byte %02h",
                                                  res_item.last_of_run, want.last_of_run,
                                                  want.out_byte));
                end
            end
            if ((src_valid && !src_stall) || (res_valid && !res_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("[lyric_timestamp_stripper] ERROR");
        $finish;
    end

    initial
    begin
        int         target;
        logic [7:0] opener;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    add_byte(8'h00);
                    add_byte(8'hFF);
                    add_byte(CH_CR);
                    add_byte(CH_NL);
                    add_mark(1'b0, 1'b0);
                    add_mark(1'b1, 1'b0);
                    add_byte(CH_NL);
                    add_str("[a:]\n");
                    add_str("[9");
                    add_end();
                    add_str("<1:23>");
                end
                1:
                begin
                    send_idle_pct = 57;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 57;
                    add_byte(CH_NL);
                    add_byte($urandom_range(1) ? CH_LBRK : CH_LT);
                    add_letters($urandom_range(66, 62));
                    add_byte($urandom_range(1) ? CH_RBRK : CH_GT);
                end
                default:
                begin
                    send_idle_pct = 7;
                    stall_pct     = 7;
                end
            endcase

            target = src_q.size() + 15;
            while (src_q.size() < target)
            begin
                case ($urandom_range(9))
                    0, 1:
                    begin
                        add_stamp(1'($urandom_range(1)), 1'b0);
                        add_text($urandom_range(6));
                        add_byte(CH_NL);
                    end
                    2:
                    begin
                        add_stamp(1'($urandom_range(1)), 1'b1);
                        add_text($urandom_range(3));
                    end
                    3:
                    begin
                        add_byte(CH_LBRK);
                        add_letters($urandom_range(3, 1));
                        add_byte(CH_COLON);
                        add_text($urandom_range(3));
                        add_byte(CH_RBRK);
                        add_text($urandom_range(3));
                        add_byte(CH_NL);
                    end
                    4:
                    begin
                        add_mark(1'b0, $urandom_range(3) == 0);
                        add_text($urandom_range(4));
                        add_mark(1'b1, $urandom_range(3) == 0);
                        if ($urandom_range(1))
                            add_byte(CH_NL);
                    end
                    5:
                    begin
                        repeat ($urandom_range(4, 1))
                            add_byte(8'($urandom_range(255)));
                    end
                    6:
                        add_byte($urandom_range(1) ? CH_CR : CH_NL);
                    7:
                    begin
                        case ($urandom_range(2))
                            0: opener = CH_LBRK;
                            1: opener = CH_LT;
                            default: opener = SNC_B0;
                        endcase
                        add_byte(opener);
                        if (opener == SNC_B0 && $urandom_range(1))
                            add_byte(SNC_B1);
                        else
                            add_text($urandom_range(3));
                        add_end();
                    end
                    8:
                    begin
                        add_byte($urandom_range(1) ? CH_LBRK : CH_LT);
                        add_text($urandom_range(4));
                        add_byte(CH_NL);
                    end
                    default:
                    begin
                        if ($urandom_range(1))
                        begin
                            add_byte(CH_LBRK);
                            add_text($urandom_range(4));
                            add_byte(CH_RBRK);
                        end
                        else
                        begin
                            add_byte(CH_LT);
                            add_text($urandom_range(4));
                            add_byte(CH_GT);
                        end
                    end
                endcase
            end

            while (src_q.size() != 0 || src_valid)
                @(posedge clk);
            while (filtered_q.size() != 0)
                @(posedge clk);
        end

        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (filtered_q.size() != 0)
            report_mismatch($sformatf("%0d expected bytes never arrived", filtered_q.size()));
        if (mismatches == 0)
            $display("[lyric_timestamp_stripper] OK");
        else
            $display("[lyric_timestamp_stripper] ERROR");
        $finish;
    end

endmodule
